// ===== design/tcw_pkg.sv =====
// tcw_pkg: screen geometry, field widths, action and character codes,
// and the structs shared by the text console writer modules.
// No dependencies.
package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int MOVE_COUNT     = CELL_COUNT - SCREEN_COLUMNS;
  localparam int ADDR_W         = $clog2(CELL_COUNT);

  localparam int ACT_W  = 2;
  localparam int CODE_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int OFFS_W = 11;
  localparam int WORD_W = 16;
  localparam int ATTR_W = 8;

  localparam int IN_BITS  = CODE_W + COL_W + ROW_W + IDX_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int RES_BITS = COL_W + ROW_W + OFFS_W + WORD_W;
  localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

  // actions
  localparam logic [ACT_W-1:0] ACT_PUT   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SET   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd3;

  // character codes
  localparam logic [CODE_W-1:0] CH_BS    = 8'h08;
  localparam logic [CODE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CODE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CODE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CODE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CODE_W-1:0] CH_TOP   = 8'h7F;
  localparam int                TAB_STEP = 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTR   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]  cell_index;
    logic [ROW_W-1:0]  new_row;
    logic [COL_W-1:0]  new_col;
    logic [CODE_W-1:0] char_code;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] cell_word;
    logic [OFFS_W-1:0] cursor_offset;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(int'(row) * SCREEN_COLUMNS + int'(col));
  endfunction

endpackage

// ===== design/tcw_screen_mem.sv =====
// tcw_screen_mem: screen store, one write port and one registered read port.
// Depends on tcw_pkg.
module tcw_screen_mem import tcw_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== design/tcw_engine.sv =====
// tcw_engine: sequencer, cursor and the shared address counter that walks
// the screen store for the reset clear, clear screen and scroll.
// Depends on tcw_pkg.
module tcw_engine import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACT_W-1:0]  action,
  input  item_t             item,
  input  logic [ATTR_W-1:0] text_attr,
  input  logic              display_enable,
  input  logic              take,
  input  logic [WORD_W-1:0] rd_data,
  output mem_req_t          mem_req,
  output logic              idle,
  output logic              done,
  output result_t           result
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_EXEC   = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_FILL   = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0]        state;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] pend_addr;
  logic              pend;
  logic              rd_ok;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [WORD_W-1:0] fill_word;
  logic [ACT_W-1:0]  act;
  item_t             it;

  // put-char decode
  logic [COL_W-1:0]  pc_col;
  logic [ROW_W:0]    pc_row;
  logic              pc_we;
  logic [ADDR_W-1:0] pc_addr;
  logic [WORD_W-1:0] pc_data;
  logic [COL_W:0]    tab_sum;
  logic [COL_W:0]    tab_col;
  logic              need_scroll;
  logic              idx_ok;
  logic [WORD_W-1:0] blank;

  assign blank   = {text_attr, CH_SPACE};
  assign tab_sum = {1'b0, col} + (COL_W+1)'(TAB_STEP);
  assign tab_col = tab_sum & ~(COL_W+1)'(TAB_STEP - 1);
  assign idx_ok  = 32'(it.cell_index) < CELL_COUNT;

  always_comb begin
    pc_col  = col;
    pc_row  = {1'b0, row};
    pc_we   = 1'b0;
    pc_addr = cell_addr(row, col);
    pc_data = {text_attr, it.char_code};
    if (it.char_code == CH_NL) begin
      pc_col = '0;
      pc_row = {1'b0, row} + 1'b1;
    end else if (it.char_code == CH_CR) begin
      pc_col = '0;
    end else if (it.char_code == CH_TAB) begin
      if (tab_col >= (COL_W+1)'(SCREEN_COLUMNS)) begin
        pc_col = '0;
        pc_row = {1'b0, row} + 1'b1;
      end else begin
        pc_col = tab_col[COL_W-1:0];
      end
    end else if (it.char_code == CH_BS) begin
      if (col != '0) begin
        pc_col  = col - 1'b1;
        pc_we   = 1'b1;
        pc_addr = cell_addr(row, col - 1'b1);
        pc_data = blank;
      end
    end else if (it.char_code >= CH_SPACE && it.char_code <= CH_TOP) begin
      pc_we = 1'b1;
      if ({1'b0, col} + 1'b1 >= (COL_W+1)'(SCREEN_COLUMNS)) begin
        pc_col = '0;
        pc_row = {1'b0, row} + 1'b1;
      end else begin
        pc_col = col + 1'b1;
      end
    end
  end

  assign need_scroll = pc_row >= (ROW_W+1)'(SCREEN_ROWS);

  // store port requests
  always_comb begin
    mem_req = '0;
    case (state)
      ST_INIT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr;
      end
      ST_FILL: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = addr;
        mem_req.wdata = fill_word;
      end
      ST_EXEC: begin
        if (act == ACT_PUT && display_enable) begin
          mem_req.we    = pc_we;
          mem_req.waddr = pc_addr;
          mem_req.wdata = pc_data;
        end
        if (act == ACT_READ && idx_ok) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(it.cell_index);
        end
      end
      ST_SCROLL: begin
        // read one line below, write back what was read last cycle
        mem_req.re    = 1'b1;
        mem_req.raddr = addr + ADDR_W'(SCREEN_COLUMNS);
        mem_req.we    = pend;
        mem_req.waddr = pend_addr;
        mem_req.wdata = rd_data;
      end
      ST_TAIL: begin
        mem_req.we = 1'b1;
        if (pend) begin
          mem_req.waddr = pend_addr;
          mem_req.wdata = rd_data;
        end else begin
          mem_req.waddr = addr;
          mem_req.wdata = fill_word;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      addr  <= '0;
      pend  <= 1'b0;
      rd_ok <= 1'b0;
      col   <= '0;
      row   <= '0;
    end else begin
      pend <= (state == ST_SCROLL);
      case (state)
        ST_INIT: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_W'(CELL_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            act   <= action;
            it    <= item;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rd_ok <= (act == ACT_READ) && idx_ok;
          case (act)
            ACT_PUT: begin
              if (display_enable) begin
                col <= pc_col;
                if (need_scroll) begin
                  row       <= ROW_W'(SCREEN_ROWS - 1);
                  addr      <= '0;
                  fill_word <= blank;
                  state     <= ST_SCROLL;
                end else begin
                  row   <= pc_row[ROW_W-1:0];
                  state <= ST_FINISH;
                end
              end else begin
                state <= ST_FINISH;
              end
            end
            ACT_CLEAR: begin
              if (display_enable) begin
                col       <= '0;
                row       <= '0;
                addr      <= '0;
                fill_word <= blank;
                state     <= ST_FILL;
              end else begin
                state <= ST_FINISH;
              end
            end
            ACT_SET: begin
              if ({1'b0, it.new_col} < (COL_W+1)'(SCREEN_COLUMNS)) begin
                col <= it.new_col;
              end
              if ({1'b0, it.new_row} < (ROW_W+1)'(SCREEN_ROWS)) begin
                row <= it.new_row;
              end
              state <= ST_FINISH;
            end
            ACT_READ: begin
              state <= ST_FINISH;
            end
            default: begin
              state <= ST_FINISH;
            end
          endcase
        end
        ST_SCROLL: begin
          pend_addr <= addr;
          addr      <= addr + 1'b1;
          if (addr == ADDR_W'(MOVE_COUNT - 1)) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: begin
          if (!pend) begin
            addr <= addr + 1'b1;
            if (addr == ADDR_W'(CELL_COUNT - 1)) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FILL: begin
          addr <= addr + 1'b1;
          if (addr == ADDR_W'(CELL_COUNT - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign idle = (state == ST_IDLE);
  assign done = (state == ST_FINISH);

  always_comb begin
    result.cursor_col    = col;
    result.cursor_row    = row;
    result.cursor_offset = OFFS_W'(cell_addr(row, col));
    result.cell_word     = rd_ok ? rd_data : '0;
  end

endmodule

// ===== design/text_console_writer.sv =====
// text_console_writer: top level; stream ports, configuration registers and
// output register around the console engine and the screen store.
// Depends on tcw_pkg, tcw_engine, tcw_screen_mem.
//
// Usage:
//   Items come in on the s_ group (action in s_tuser, the other fields in
//   s_tdata); every item gives one result word on the m_ group. Config is a
//   plain write port (cfg_we, cfg_index, cfg_data): index 0 text attribute,
//   index 1 display enable; write it only while the block is idle.
//   For plain and control characters, set cursor and read cell the engine
//   passes through its exec and finish states before the result is
//   registered. Clear screen and a scrolling character walk the whole
//   80 x 25 store, one cell a cycle on the store write port. One item at a
//   time; s_tready is low meanwhile.
//   After reset the store is cleared to zero by a pass over every cell
//   with s_tready low; config writes are still taken then.
//   The result sits in an output register, so the next item is taken while
//   a result waits; if the receiver stalls longer, the engine holds the
//   following result and s_tready stays low until the register frees.
module text_console_writer import tcw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_W-1:0]      s_tdata,   // char_code, new_col, new_row, cell_index
  input  logic [ACT_W-1:0]     s_tuser,   // action
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // cursor_col, cursor_row, cursor_offset, cell_word
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [ATTR_W-1:0] text_attr;
  logic              display_enable;
  logic              start;
  logic              take;
  logic              eng_idle;
  logic              eng_done;
  result_t           eng_res;
  result_t           out_res;
  item_t             item;
  mem_req_t          mem_req;
  logic [WORD_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attr      <= ATTR_W'(7);
      display_enable <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ATTR:   text_attr      <= cfg_data[ATTR_W-1:0];
        CFG_ENABLE: display_enable <= cfg_data[0];
        default:    text_attr      <= text_attr;
      endcase
    end
  end

  assign item     = item_t'(s_tdata[IN_BITS-1:0]);
  assign s_tready = eng_idle;
  assign start    = s_tvalid & s_tready;
  assign take     = !m_tvalid || m_tready;

  tcw_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .action         (s_tuser),
    .item           (item),
    .text_attr      (text_attr),
    .display_enable (display_enable),
    .take           (take),
    .rd_data        (rd_data),
    .mem_req        (mem_req),
    .idle           (eng_idle),
    .done           (eng_done),
    .result         (eng_res)
  );

  tcw_screen_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_done && take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done && take) begin
      out_res <= eng_res;
    end
  end

  assign m_tdata = OUT_W'(out_res);

  // one item in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second word taken while engine busy");

  // store clearing pass blocks input after reset
  a_init_pass: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input taken during reset clear");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (int'(out_res.cursor_col) < SCREEN_COLUMNS) &&
                 (int'(out_res.cursor_row) < SCREEN_ROWS))
    else $error("cursor out of screen");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_res.cursor_offset ==
                 OFFS_W'(cell_addr(out_res.cursor_row, out_res.cursor_col)))
    else $error("cursor offset does not match row and column");

endmodule
